// ===== rtl/chist_pkg.sv =====
// ----------------------------------------------------------------------------
// chist_pkg
// Shared types and constants of the cumulative histogram accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package chist_pkg;

    localparam int BOUND_W     = 32;
    localparam int SUM_W       = 64;
    localparam int OUT_CNT_W   = 32;
    localparam int SLOT_W      = 3;
    localparam int NUM_BOUNDS  = 7;
    localparam int NUM_SLOTS   = 8;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [SLOT_W-1:0]  INF_SLOT  = 3'd7;
    localparam logic [BOUND_W-1:0] BOUND_MAX = 32'h7FFF_FFFF;

    localparam int DEF_FINITE_BUCKETS = 7;
    localparam int DEF_COUNT_WIDTH    = 32;

    typedef enum logic {
        CMD_OBSERVE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                       command;
        logic signed [BOUND_W-1:0]  sample;
        logic [SLOT_W-1:0]          bucket_index;
    } item_t;

    typedef struct packed {
        logic signed [BOUND_W-1:0]  bucket_bound;
        logic                       is_infinite;
        logic [OUT_CNT_W-1:0]       bucket_count;
        logic signed [SUM_W-1:0]    sample_sum;
        logic [OUT_CNT_W-1:0]       obs_total;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/chist_bucket_bank.sv =====
// ----------------------------------------------------------------------------
// chist_bucket_bank
// Bound registers, cumulative bucket counters, running sum and sample total.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_bucket_bank #(
    parameter int FINITE_BUCKETS = chist_pkg::DEF_FINITE_BUCKETS,
    parameter int COUNT_WIDTH    = chist_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [chist_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [chist_pkg::BOUND_W-1:0]          cfg_wr_data,
    input  wire logic                                   obs_en,
    input  wire logic signed [chist_pkg::BOUND_W-1:0]   obs_sample,
    input  wire logic [chist_pkg::SLOT_W-1:0]           rd_idx,
    output chist_pkg::result_t                          rd_data
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [chist_pkg::BOUND_W-1:0]  bound_reg [chist_pkg::NUM_BOUNDS];
    logic [COUNT_WIDTH-1:0]         cnt_reg   [chist_pkg::NUM_SLOTS];
    logic [chist_pkg::SUM_W-1:0]    sum_reg;
    logic [COUNT_WIDTH-1:0]         total_reg;
    logic [chist_pkg::NUM_SLOTS-1:0] hit;
    logic [COUNT_WIDTH-1:0]         rd_cnt;
    logic [chist_pkg::OUT_CNT_W-1:0] rd_cnt_out;
    logic [chist_pkg::OUT_CNT_W-1:0] total_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < chist_pkg::NUM_BOUNDS; i++) begin
                bound_reg[i] <= chist_pkg::BOUND_MAX;
            end
        end else if (cfg_wr_en && (cfg_addr != chist_pkg::INF_SLOT)) begin
            bound_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    // Compare against all bounds at once; slots past FINITE_BUCKETS never count.
    genvar g;
    generate
        for (g = 0; g < chist_pkg::NUM_BOUNDS; g++) begin : g_hit
            if (g < FINITE_BUCKETS) begin : g_used
                assign hit[g] = (obs_sample <= $signed(bound_reg[g]));
            end else begin : g_unused
                assign hit[g] = 1'b0;
            end
        end
    endgenerate
    assign hit[chist_pkg::INF_SLOT] = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < chist_pkg::NUM_SLOTS; i++) begin
                cnt_reg[i] <= '0;
            end
            sum_reg   <= '0;
            total_reg <= '0;
        end else if (obs_en) begin
            for (int i = 0; i < chist_pkg::NUM_SLOTS; i++) begin
                if (hit[i] && (cnt_reg[i] != COUNT_MAX)) begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
            sum_reg <= sum_reg + {{(chist_pkg::SUM_W-chist_pkg::BOUND_W){obs_sample[
                chist_pkg::BOUND_W-1]}}, obs_sample};
            if (total_reg != COUNT_MAX) begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    assign rd_cnt = cnt_reg[rd_idx];

    generate
        if (COUNT_WIDTH >= chist_pkg::OUT_CNT_W) begin : g_cnt_trunc
            assign rd_cnt_out = rd_cnt[chist_pkg::OUT_CNT_W-1:0];
            assign total_out  = total_reg[chist_pkg::OUT_CNT_W-1:0];
        end else begin : g_cnt_ext
            assign rd_cnt_out = {{(chist_pkg::OUT_CNT_W-COUNT_WIDTH){1'b0}}, rd_cnt};
            assign total_out  = {{(chist_pkg::OUT_CNT_W-COUNT_WIDTH){1'b0}}, total_reg};
        end
    endgenerate

    always_comb begin
        rd_data.is_infinite  = (rd_idx == chist_pkg::INF_SLOT);
        rd_data.bucket_bound = chist_pkg::BOUND_MAX;
        if (rd_idx != chist_pkg::INF_SLOT) begin
            rd_data.bucket_bound = bound_reg[rd_idx[chist_pkg::SLOT_W-1:0]];
        end
        rd_data.bucket_count = rd_cnt_out;
        rd_data.sample_sum   = sum_reg;
        rd_data.obs_total    = total_out;
    end

endmodule

`default_nettype wire

// ===== rtl/chist_out_skid.sv =====
// ----------------------------------------------------------------------------
// chist_out_skid
// Result register with one skid entry toward the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_out_skid (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  chist_pkg::result_t  push_data,
    output logic                space,
    output logic                m_valid,
    input  wire logic           m_ready,
    output chist_pkg::result_t  m_data
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    chist_pkg::result_t main_reg;
    chist_pkg::result_t skid_reg;
    logic               pop;

    assign pop     = main_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                // advance the skid entry; a new item takes its place
                skid_valid_reg <= push;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (push) begin
                    skid_reg <= push_data;
                end
            end else if (push) begin
                main_reg <= push_data;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_reg <= push_data;
            end else begin
                main_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cumulative_histogram_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// cumulative_histogram_accumulator_top
// Cumulative bucket histogram of signed latency samples.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one command item per handshake: s_tuser selects
// observe (0) or read (1). An observe adds the sample to the 64-bit wrapping
// sum, bumps the saturating total and every bucket whose bound is at or above
// the sample; it gives no result. A read returns one item on the master
// channel with the bucket bound, count, sum and total; m_tuser on the master
// side flags the +Inf bucket. Bounds are to be written through the cfg port
// only while the block is idle; the block itself does not enforce this.
// Timing: an item is held in the input register; a read result is then
// registered in the output register, which drives m_tvalid.
// Throughput: one item per cycle while reads find a free output entry, set
// by the combinational compare-and-count path from the input register into
// the counters and result register.
// Reset clears all counters, the sum and the total, and sets every bound to
// the largest positive value. When the receiver stalls, one read result is
// held in the output register and one more in a skid entry; after that reads
// stall the input, while observes still drain.
// ----------------------------------------------------------------------------
`default_nettype none

module cumulative_histogram_accumulator_top #(
    parameter int FINITE_BUCKETS = chist_pkg::DEF_FINITE_BUCKETS,
    parameter int COUNT_WIDTH    = chist_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [chist_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [chist_pkg::BOUND_W-1:0]      cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [39:0]                        s_tdata,  // sample, bucket_index, pad
    input  wire logic [0:0]                         s_tuser,  // command
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [159:0]                            m_tdata,  // bucket_bound, bucket_count,
                                                              // sample_sum, obs_total
    output logic [0:0]                              m_tuser   // is_infinite
);

    chist_pkg::item_t   item_reg;
    logic               item_valid_reg;
    logic               advance;
    logic               is_read;
    logic               space;
    chist_pkg::result_t rd_data;
    chist_pkg::result_t out_data;

    assign is_read  = (item_reg.command == chist_pkg::CMD_READ);
    // observes always drain; reads need a free output entry
    assign advance  = item_valid_reg && (!is_read || space);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.command      <= chist_pkg::cmd_t'(s_tuser[0]);
            item_reg.sample       <= s_tdata[31:0];
            item_reg.bucket_index <= s_tdata[34:32];
        end
    end

    chist_bucket_bank #(
        .FINITE_BUCKETS (FINITE_BUCKETS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .obs_en      (advance && !is_read),
        .obs_sample  (item_reg.sample),
        .rd_idx      (item_reg.bucket_index),
        .rd_data     (rd_data)
    );

    chist_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance && is_read),
        .push_data (rd_data),
        .space     (space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {out_data.obs_total, out_data.sample_sum,
                      out_data.bucket_count, out_data.bucket_bound};
    assign m_tuser = out_data.is_infinite;

endmodule

`default_nettype wire
